>>> hw/rtl/kled_pkg.sv
// kled_pkg: constants, lookup tables and shared types of the key to led colour mapper
// no dependencies; imported by kled_key_stage, kled_expander and key_to_led_color_mapper_unit

package kled_pkg;

  // table markers and limits
  localparam logic [7:0] NoLed      = 8'hff;
  localparam logic [7:0] MultiBase  = 8'he0;
  localparam int         RowLimit   = 10;
  localparam int         ColLimit   = 14;
  localparam int         HighLimit  = 9;
  localparam int         WordOffset = 7;
  localparam int         MaxWrites  = 4;
  localparam int         MultiLen   = 14;

  // channel order across buffer pages 0, 1 and 2
  typedef enum logic [1:0] {
    ORD_RGB,
    ORD_BRG,
    ORD_GBR
  } chan_order_e;

  // led code per key, rows 1 to 9 and columns 0 to 13
  localparam logic [7:0] KeyCode [9][14] = '{
    '{8'h40, 8'h42, 8'h46, 8'h44, 8'h43, 8'h45, 8'h38,
      8'h37, 8'h39, 8'h3e, 8'h33, 8'h3a, 8'h3d, 8'h3b},
    '{8'h4e, 8'h4f, 8'h48, 8'h4a, 8'h49, 8'h47, 8'h4b,
      8'h36, 8'h34, 8'h35, 8'h32, 8'h31, 8'h2b, 8'h3f},
    '{8'h51, 8'h4d, 8'h55, 8'h4c, 8'h52, 8'h54, 8'h53,
      8'h13, 8'h15, 8'h14, 8'h12, 8'h16, 8'h17, 8'h18},
    '{8'h50, 8'h5f, 8'h57, 8'h59, 8'h58, 8'h56, 8'h5a,
      8'h11, 8'h1d, 8'h1f, 8'h10, 8'h1c, 8'h1e, 8'h2f},
    '{8'h74, 8'h5e, 8'h76, 8'h5c, 8'h75, 8'h60, 8'h5d,
      8'h61, 8'h5b, 8'h62, 8'h64, 8'h1b, 8'h1a, 8'h19},
    '{8'h73, 8'h71, 8'h23, 8'h72, 8'h77, 8'h78, 8'h6e,
      8'h6b, 8'h64, 8'h6f, 8'h65, 8'h2e, 8'h63, 8'h66},
    '{8'h7e, 8'h70, 8'h7c, 8'h7f, 8'h7a, 8'h79, 8'h7b,
      8'h69, 8'h0e, 8'h0f, 8'h20, 8'h21, 8'h22, 8'h67},
    '{8'hff, 8'hff, 8'he3, 8'he0, 8'h7d, 8'h09, 8'h0b,
      8'h0a, 8'h0c, 8'h0d, 8'h00, 8'h03, 8'h2d, 8'h01},
    '{8'he9, 8'hff, 8'he6, 8'hff, 8'h80, 8'h81, 8'h08,
      8'h2c, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'h02}
  };

  // runs of led codes for multi-led keys, each closed by an end marker
  localparam logic [7:0] MultiRun [14] = '{
    8'h8d, 8'h8b, 8'hff,
    8'h8e, 8'h8a, 8'hff,
    8'h8f, 8'h89, 8'hff,
    8'h85, 8'h86, 8'h88, 8'h87, 8'hff
  };

  // channel order per led, by high then low nibble
  function automatic chan_order_e chan_order_f(logic [3:0] hi, logic [3:0] lo);
    chan_order_e ord;
    unique case (hi)
      4'd0, 4'd8: ord = ORD_GBR;
      4'd1, 4'd5: ord = lo[3] ? ORD_BRG : ORD_RGB;
      4'd2: begin
        unique case (lo)
          4'd0, 4'd1, 4'd2, 4'd12, 4'd13: ord = ORD_GBR;
          4'd3, 4'd14, 4'd15:             ord = ORD_BRG;
          default:                        ord = ORD_RGB;
        endcase
      end
      4'd6:    ord = ORD_BRG;
      4'd7:    ord = lo[3] ? ORD_GBR : ORD_BRG;
      default: ord = ORD_RGB;
    endcase
    return ord;
  endfunction

  typedef logic [MaxWrites-1:0][7:0] code_list_t;

  // looked-up key passed from the key stage to the expander
  typedef struct packed {
    logic        valid;
    logic [7:0]  code;
    logic [15:0] red;
    logic [15:0] green;
    logic [15:0] blue;
  } key_stage_t;

endpackage

>>> hw/rtl/kled_if.sv
// kled_key_if and kled_wr_if: valid/ready channels for key updates and buffer writes
// no dependencies

interface kled_key_if;
  logic        valid;
  logic        ready;
  logic [3:0]  key_row;
  logic [3:0]  key_col;
  logic [15:0] red;
  logic [15:0] green;
  logic [15:0] blue;

  modport source (output valid, key_row, key_col, red, green, blue, input ready);
  modport sink   (input valid, key_row, key_col, red, green, blue, output ready);
endinterface

interface kled_wr_if;
  logic        valid;
  logic        ready;
  logic [7:0]  word_index;
  logic [15:0] page0_value;
  logic [15:0] page1_value;
  logic [15:0] page2_value;
  logic        last_write;

  modport source (output valid, word_index, page0_value, page1_value, page2_value,
                  last_write, input ready);
  modport sink   (input valid, word_index, page0_value, page1_value, page2_value,
                  last_write, output ready);
endinterface

>>> hw/rtl/kled_key_stage.sv
// kled_key_stage: takes a key transaction and reads its led code from the key rom
// depends on kled_pkg

module kled_key_stage
  import kled_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        valid_i,
  input  logic [3:0]  row_i,
  input  logic [3:0]  col_i,
  input  logic [15:0] red_i,
  input  logic [15:0] green_i,
  input  logic [15:0] blue_i,
  output logic        ready_o,
  input  logic        advance_i,
  output key_stage_t  stage_o
);

  logic        valid_q;
  logic [7:0]  code_q;
  logic [15:0] red_q, green_q, blue_q;
  logic        key_ok;
  logic [3:0]  row_idx;
  logic [7:0]  code_d;

  // key position check and rom address
  assign key_ok  = (row_i != 4'd0) && (row_i < 4'(RowLimit)) && (col_i < 4'(ColLimit));
  assign row_idx = row_i - 4'd1;
  assign code_d  = key_ok ? KeyCode[row_idx][col_i] : NoLed;

  assign ready_o = !valid_q || advance_i;

  // stage valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  // registered rom read and colour capture
  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      code_q  <= code_d;
      red_q   <= red_i;
      green_q <= green_i;
      blue_q  <= blue_i;
    end
  end

  assign stage_o = '{valid: valid_q, code: code_q, red: red_q, green: green_q, blue: blue_q};

endmodule

>>> hw/rtl/kled_expander.sv
// kled_expander: expands a led code or multi-led run into buffer writes, one per cycle while wr_ready_i is high
// depends on kled_pkg; drives the output register of the block

module kled_expander
  import kled_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  key_stage_t  stage_i,
  output logic        take_o,
  output logic        wr_valid_o,
  input  logic        wr_ready_i,
  output logic [7:0]  word_index_o,
  output logic [15:0] page0_value_o,
  output logic [15:0] page1_value_o,
  output logic [15:0] page2_value_o,
  output logic        last_write_o
);

  code_list_t           list_d;
  logic [MaxWrites-1:0] load_mask;
  code_list_t           codes_q;
  logic [MaxWrites-1:0] mask_q, mask_d;
  logic                 exp_valid_q, exp_valid_d;
  logic [15:0]          red_q, green_q, blue_q;
  logic [MaxWrites-1:0] low_bit, remaining;
  logic [1:0]           sel;
  logic [7:0]           cur_code;
  logic [3:0]           cur_lo, cur_hi;
  chan_order_e          cur_ord;
  logic                 out_free, emit, exp_done, load;
  logic                 out_valid_q;
  logic [7:0]           word_index_q;
  logic [15:0]          page0_q, page1_q, page2_q;
  logic [15:0]          page0_d, page1_d, page2_d;
  logic                 last_q;

  // write list: the code itself below MultiBase, else walk the run table for a multi-led code, stop at the end marker
  always_comb begin
    logic [5:0] idx;
    logic       alive;
    logic       below_multi;
    below_multi = stage_i.code < MultiBase;
    alive       = 1'b1;
    for (int n = 0; n < MaxWrites; n++) begin
      idx = {1'b0, stage_i.code[4:0]} + 6'(n);
      if (below_multi) begin
        list_d[n]    = (n == 0) ? stage_i.code : NoLed;
        load_mask[n] = (n == 0) && (stage_i.code[7:4] < 4'(HighLimit));
      end else begin
        alive        = alive && (idx < 6'(MultiLen)) && (MultiRun[idx[3:0]] != NoLed);
        list_d[n]    = alive ? MultiRun[idx[3:0]] : NoLed;
        load_mask[n] = alive && (list_d[n][7:4] < 4'(HighLimit));
      end
    end
  end

  // pick the next pending write
  assign low_bit   = mask_q & (~mask_q + 4'd1);
  assign remaining = mask_q & ~low_bit;

  always_comb begin
    priority if (mask_q[0]) sel = 2'd0;
    else if (mask_q[1])     sel = 2'd1;
    else if (mask_q[2])     sel = 2'd2;
    else                    sel = 2'd3;
  end

  assign out_free = !out_valid_q || wr_ready_i;
  assign emit     = exp_valid_q && out_free;
  assign exp_done = emit && (remaining == '0);
  assign take_o   = !exp_valid_q || exp_done;
  assign load     = take_o && stage_i.valid && (load_mask != '0);

  // expander state, keys without writes are dropped here
  always_comb begin
    exp_valid_d = exp_valid_q;
    mask_d      = mask_q;
    if (take_o) begin
      exp_valid_d = load;
      mask_d      = load_mask;
    end else if (emit) begin
      mask_d      = remaining;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      exp_valid_q <= 1'b0;
      mask_q      <= '0;
    end else begin
      exp_valid_q <= exp_valid_d;
      mask_q      <= mask_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      codes_q <= list_d;
      red_q   <= stage_i.red;
      green_q <= stage_i.green;
      blue_q  <= stage_i.blue;
    end
  end

  // word index and channel permutation of the selected led
  assign cur_code = codes_q[sel];
  assign cur_lo   = cur_code[3:0];
  assign cur_hi   = cur_code[7:4];
  assign cur_ord  = chan_order_f(cur_hi, cur_lo);

  always_comb begin
    unique case (cur_ord)
      ORD_BRG: begin
        page0_d = blue_q;  page1_d = red_q;   page2_d = green_q;
      end
      ORD_GBR: begin
        page0_d = green_q; page1_d = blue_q;  page2_d = red_q;
      end
      default: begin
        page0_d = red_q;   page1_d = green_q; page2_d = blue_q;
      end
    endcase
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      word_index_q <= {cur_lo, 4'h0} + {4'h0, cur_hi} + 8'(WordOffset);
      page0_q      <= page0_d;
      page1_q      <= page1_d;
      page2_q      <= page2_d;
      last_q       <= (remaining == '0);
    end
  end

  assign wr_valid_o    = out_valid_q;
  assign word_index_o  = word_index_q;
  assign page0_value_o = page0_q;
  assign page1_value_o = page1_q;
  assign page2_value_o = page2_q;
  assign last_write_o  = last_q;

endmodule

>>> hw/rtl/key_to_led_color_mapper_unit.sv
// key_to_led_color_mapper_unit: top level of the key to led colour mapper
// depends on kled_pkg, kled_if, kled_key_stage and kled_expander
//
// Usage
//   key_i carries one key colour update per transaction: matrix row and column
//   and 16-bit red, green and blue values. wr_o carries frame-buffer write
//   transactions: word index, three permuted page values and last_write, which
//   marks the final write caused by a key. A key gives zero to four writes.
//   The first write of a key passes through the registered key rom read, the
//   expander register and the output register.
//   Throughput: one key per cycle for keys that map to one led, while wr_o.ready
//   is high; a multi-led key holds the expander until its last write, up to four,
//   and the input stalls meanwhile. Keys without a valid position or without an
//   led are dropped in the expander without writes.
//   Reset clears all valid flags; no write is pending after reset.
//   When wr_o.ready is low the output register holds its write, the expander
//   and key stage fill behind it and then key_i.ready drops.

module key_to_led_color_mapper_unit
  import kled_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  kled_key_if.sink    key_i,
  kled_wr_if.source   wr_o
);

  key_stage_t stage;
  logic       take;

  kled_key_stage u_key_stage (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .valid_i   (key_i.valid),
    .row_i     (key_i.key_row),
    .col_i     (key_i.key_col),
    .red_i     (key_i.red),
    .green_i   (key_i.green),
    .blue_i    (key_i.blue),
    .ready_o   (key_i.ready),
    .advance_i (take),
    .stage_o   (stage)
  );

  kled_expander u_expander (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .stage_i       (stage),
    .take_o        (take),
    .wr_valid_o    (wr_o.valid),
    .wr_ready_i    (wr_o.ready),
    .word_index_o  (wr_o.word_index),
    .page0_value_o (wr_o.page0_value),
    .page1_value_o (wr_o.page1_value),
    .page2_value_o (wr_o.page2_value),
    .last_write_o  (wr_o.last_write)
  );

endmodule

>>> hw/rtl/kled_checker.sv
// kled_checker: port-level assertions for the key to led colour mapper
// depends on key_to_led_color_mapper_unit, attached by the bind at the end

module kled_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        wr_valid_i,
  input logic        wr_ready_i,
  input logic [7:0]  word_index_i,
  input logic [15:0] page0_value_i,
  input logic [15:0] page1_value_i,
  input logic [15:0] page2_value_i,
  input logic        last_write_i
);

  // a stalled write keeps its contents
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_valid_i && !wr_ready_i |=> wr_valid_i && $stable(word_index_i)
      && $stable(page0_value_i) && $stable(page1_value_i)
      && $stable(page2_value_i) && $stable(last_write_i))
    else $error("stalled write changed");

  // high nibble below nine plus the offset never carries out of the low nibble
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_valid_i |-> word_index_i[3:0] >= 4'd7)
    else $error("word index outside the led range");

  // no write pending straight out of reset
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$past(rst_ni) |-> !wr_valid_i)
    else $error("write pending after reset");

endmodule

bind key_to_led_color_mapper_unit kled_checker u_kled_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .wr_valid_i    (wr_o.valid),
  .wr_ready_i    (wr_o.ready),
  .word_index_i  (wr_o.word_index),
  .page0_value_i (wr_o.page0_value),
  .page1_value_i (wr_o.page1_value),
  .page2_value_i (wr_o.page2_value),
  .last_write_i  (wr_o.last_write)
);
